// ===== sv/ppmd_pkg.sv =====
// shared types and constants for the ppm frame decoder
`default_nettype none

package ppmd_pkg;

    localparam int N_CHANNELS    = 8;
    localparam int TICK_DIV      = 1;
    localparam int ACQUIRE_SYNCS = 8;

    localparam int CH_W   = $clog2(N_CHANNELS + 1);
    localparam int ACQ_W  = 4;
    localparam int TICK_W = 16;
    localparam int US_W   = 16;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] SYNC_GAP_RESET  = 16'd3000;
    localparam logic [CFG_W-1:0] MIN_PULSE_RESET = 16'd750;
    localparam logic [CFG_W-1:0] MAX_PULSE_RESET = 16'd2250;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd2;

    typedef enum logic [2:0] {
        KIND_INTERVAL = 3'd0,
        KIND_OVERFLOW = 3'd1,
        KIND_READ     = 3'd2,
        KIND_FS_WRITE = 3'd3,
        KIND_SNAPSHOT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_NOSYNC = 2'd0,
        MODE_ACQ    = 2'd1,
        MODE_READY  = 2'd2,
        MODE_FAIL   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0] sync_gap;
        logic [CFG_W-1:0] min_pulse;
        logic [CFG_W-1:0] max_pulse;
    } t_cfg;

    typedef struct packed {
        logic [US_W-1:0] pulse_width;
        t_mode           mode;
        logic [CH_W-1:0] frame_channels;
    } t_result;

    typedef struct packed {
        t_mode            mode;
        logic [ACQ_W-1:0] acq_count;
    } t_status;

    function automatic logic [US_W-1:0] to_us(input logic [TICK_W-1:0] ticks);
        to_us = US_W'(ticks / TICK_W'(TICK_DIV));
    endfunction

endpackage

`default_nettype wire

// ===== sv/ppmd_core.sv =====
// frame state machine, pulse and failsafe stores, one request per cycle while i_accept is high
`default_nettype none

module ppmd_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [2:0]                i_kind,
    input  wire logic [ppmd_pkg::TICK_W-1:0] i_ticks,
    input  wire logic [3:0]                i_channel,
    input  wire logic [ppmd_pkg::US_W-1:0] i_fs_value,
    input  wire ppmd_pkg::t_cfg            i_cfg,
    output ppmd_pkg::t_result              o_result,
    output ppmd_pkg::t_status              o_status
);

    ppmd_pkg::t_mode                r_mode, n_mode;
    logic [ppmd_pkg::ACQ_W-1:0]     r_acq, n_acq;
    logic [ppmd_pkg::CH_W-1:0]      r_cur, n_cur;
    logic [ppmd_pkg::CH_W-1:0]      r_frame, n_frame;
    logic [ppmd_pkg::US_W-1:0]      r_pulse [0:ppmd_pkg::N_CHANNELS];
    logic [ppmd_pkg::US_W-1:0]      n_pulse [0:ppmd_pkg::N_CHANNELS];
    logic [ppmd_pkg::US_W-1:0]      r_fs    [0:ppmd_pkg::N_CHANNELS];
    logic [ppmd_pkg::US_W-1:0]      n_fs    [0:ppmd_pkg::N_CHANNELS];
    logic [ppmd_pkg::US_W-1:0]      width;
    logic [ppmd_pkg::US_W-1:0]      ticks_us;
    logic [ppmd_pkg::CH_W-1:0]      cur_inc;
    logic [ppmd_pkg::CH_W-1:0]      ch;
    logic                           ch_in_range;

    assign ticks_us    = ppmd_pkg::to_us(i_ticks);
    assign cur_inc     = r_cur + ppmd_pkg::CH_W'(1);
    assign ch_in_range = (5'(i_channel) <= 5'(ppmd_pkg::N_CHANNELS));
    assign ch          = ppmd_pkg::CH_W'(i_channel);

    always_comb begin
        n_mode  = r_mode;
        n_acq   = r_acq;
        n_cur   = r_cur;
        n_frame = r_frame;
        n_pulse = r_pulse;
        n_fs    = r_fs;
        width   = '0;
        if (i_accept) begin
            unique case (i_kind)
                ppmd_pkg::KIND_INTERVAL: begin
                    if (i_ticks >= i_cfg.sync_gap) begin
                        n_pulse[0] = ticks_us;
                        n_cur      = '0;
                        unique case (r_mode)
                            ppmd_pkg::MODE_READY: begin
                                if (r_cur != r_frame) n_mode = ppmd_pkg::MODE_FAIL;
                            end
                            ppmd_pkg::MODE_NOSYNC: begin
                                n_mode = ppmd_pkg::MODE_ACQ;
                                n_acq  = '0;
                            end
                            ppmd_pkg::MODE_ACQ: begin
                                n_acq = r_acq + ppmd_pkg::ACQ_W'(1);
                                if (n_acq > ppmd_pkg::ACQ_W'(ppmd_pkg::ACQUIRE_SYNCS)) begin
                                    n_mode  = ppmd_pkg::MODE_READY;
                                    n_frame = r_cur;
                                end
                            end
                            default: begin
                                if (r_cur == r_frame) n_mode = ppmd_pkg::MODE_READY;
                            end
                        endcase
                    end else if (r_cur < ppmd_pkg::CH_W'(ppmd_pkg::N_CHANNELS)) begin
                        if (i_ticks >= i_cfg.min_pulse && i_ticks <= i_cfg.max_pulse) begin
                            n_cur          = cur_inc;
                            n_pulse[cur_inc] = ticks_us;
                        end else if (r_mode == ppmd_pkg::MODE_READY) begin
                            n_mode = ppmd_pkg::MODE_FAIL;
                            n_cur  = '0;
                        end
                    end
                end
                ppmd_pkg::KIND_OVERFLOW: begin
                    if (r_mode == ppmd_pkg::MODE_READY) begin
                        n_mode = ppmd_pkg::MODE_FAIL;
                        n_cur  = '0;
                    end
                end
                ppmd_pkg::KIND_READ: begin
                    if (!ch_in_range) begin
                        width = '0;
                    end else if (r_mode == ppmd_pkg::MODE_FAIL && r_fs[ch] != '0) begin
                        width = r_fs[ch];
                    end else if (r_mode == ppmd_pkg::MODE_READY
                                 || r_mode == ppmd_pkg::MODE_FAIL) begin
                        width = r_pulse[ch];
                    end
                end
                ppmd_pkg::KIND_FS_WRITE: begin
                    if (ch_in_range && i_channel != 4'd0) n_fs[ch] = i_fs_value;
                end
                ppmd_pkg::KIND_SNAPSHOT: begin
                    if (r_mode == ppmd_pkg::MODE_READY) begin
                        for (int i = 1; i <= ppmd_pkg::N_CHANNELS; i++) begin
                            n_fs[i] = r_pulse[i];
                        end
                    end
                end
                default: begin
                    // unused kinds leave the state alone
                    width = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ppmd_pkg::MODE_NOSYNC;
            r_acq   <= '0;
            r_cur   <= '0;
            r_frame <= '0;
            for (int i = 0; i <= ppmd_pkg::N_CHANNELS; i++) begin
                r_pulse[i] <= '0;
                r_fs[i]    <= '0;
            end
        end else begin
            r_mode  <= n_mode;
            r_acq   <= n_acq;
            r_cur   <= n_cur;
            r_frame <= n_frame;
            r_pulse <= n_pulse;
            r_fs    <= n_fs;
        end
    end

    assign o_result.pulse_width    = width;
    assign o_result.mode           = n_mode;
    assign o_result.frame_channels = n_frame;
    assign o_status.mode           = r_mode;
    assign o_status.acq_count      = r_acq;

endmodule

`default_nettype wire

// ===== sv/ppm_frame_decoder.sv =====
// top level: config registers, decoder core and output register
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    kind, interval, channel, failsafe value
//  result    out        o_out_valid / i_out_ready  pulse width, state, channel count
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// one request per cycle while o_in_ready is high; each request yields one registered result in the next cycle
// the state update and read happen in the cycle the request is taken
// o_in_ready stays high while the output register is empty or being drained
// synchronous active-low reset restores thresholds and clears all stores
`default_nettype none

module ppm_frame_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [15:0] i_interval_ticks,
    input  wire logic [3:0]  i_channel_index,
    input  wire logic [15:0] i_failsafe_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_pulse_width,
    output logic [1:0]       o_decoder_state,
    output logic [3:0]       o_channel_count,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);

    ppmd_pkg::t_cfg    r_cfg;
    ppmd_pkg::t_result core_result;
    ppmd_pkg::t_status core_status;
    ppmd_pkg::t_result r_out;
    logic              r_out_valid;
    logic              accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap  <= ppmd_pkg::SYNC_GAP_RESET;
            r_cfg.min_pulse <= ppmd_pkg::MIN_PULSE_RESET;
            r_cfg.max_pulse <= ppmd_pkg::MAX_PULSE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppmd_pkg::CFG_SYNC_GAP:  r_cfg.sync_gap  <= i_cfg_wdata;
                ppmd_pkg::CFG_MIN_PULSE: r_cfg.min_pulse <= i_cfg_wdata;
                ppmd_pkg::CFG_MAX_PULSE: r_cfg.max_pulse <= i_cfg_wdata;
                default: begin
                    // index beyond the register list is dropped
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    ppmd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (i_kind),
        .i_ticks    (i_interval_ticks),
        .i_channel  (i_channel_index),
        .i_fs_value (i_failsafe_value),
        .i_cfg      (r_cfg),
        .o_result   (core_result),
        .o_status   (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pulse_width   = r_out.pulse_width;
    assign o_decoder_state = r_out.mode;
    assign o_channel_count = 4'(r_out.frame_channels);

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted request produced no result");

    a_width_only_when_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pulse_width != 16'd0) |->
        (o_decoder_state == ppmd_pkg::MODE_READY || o_decoder_state == ppmd_pkg::MODE_FAIL))
        else $error("nonzero pulse width outside ready or failsafe");

    a_acq_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_status.acq_count <= ppmd_pkg::ACQ_W'(ppmd_pkg::ACQUIRE_SYNCS + 1))
        else $error("acquire counter ran past the ready threshold");

    a_reset_nosync: assert property (@(posedge i_clk)
        !i_rst_n |=> (core_status.mode == ppmd_pkg::MODE_NOSYNC && !o_out_valid))
        else $error("reset did not return decoder to not synched");
`endif

endmodule

`default_nettype wire
